@@ design/csvt_pkg.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer package
// Shared types, character constants and codes for the CSV field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

   // Counter widths of the column, widest-row and row outputs.
   localparam int COLUMN_BITS = 16;
   localparam int ROW_BITS    = 32;

   // Depth of the result queue; it must hold two results on top of two in flight.
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

   // Result tdata: out_byte, column_index, row_index, widest_row, padded to bytes.
   localparam int RSP_FIELDS_W = 8 + COLUMN_BITS + ROW_BITS + COLUMN_BITS;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [7:0] CH_LF         = 8'd10;
   localparam logic [7:0] CH_CR         = 8'd13;
   localparam logic [7:0] CH_NUL        = 8'd0;
   localparam logic [7:0] DEFAULT_DELIM = 8'd44;
   localparam logic [7:0] DEFAULT_QUOTE = 8'd34;

   // Configuration register indexes.
   localparam logic [0:0] REG_DELIM = 1'b0;
   localparam logic [0:0] REG_QUOTE = 1'b1;

   // Request kinds carried on req_tuser.
   localparam logic MODE_DATA = 1'b0;
   localparam logic MODE_EOI  = 1'b1;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_ROW_END   = 2'd2,
      KIND_QUOTE_ERR = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_START   = 3'd0,
      ST_PLAIN   = 3'd1,
      ST_QUOTED  = 3'd2,
      ST_QSEEN   = 3'd3,
      ST_DRAINED = 3'd4
   } parse_state_type;

   typedef struct packed {
      logic [7:0] delim;
      logic [7:0] quote;
   } cfg_type;

   typedef struct packed {
      kind_type                 kind;
      logic [7:0]               out_byte;
      logic [COLUMN_BITS-1:0]   column_index;
      logic [ROW_BITS-1:0]      row_index;
      logic [COLUMN_BITS-1:0]   widest_row;
      logic                     last;
   } rsp_item_type;

   // Up to two results produced by one request, in order.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

`default_nettype wire

@@ design/csvt_csr.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer configuration registers
// Holds the delimiter and quote bytes and maps a zero value to the default.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [0:0]        csr_addr,
   input  wire logic [7:0]        csr_wdata,
   output csvt_pkg::cfg_type      cfg
);

   logic [7:0] delim_ff;
   logic [7:0] quote_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= csvt_pkg::DEFAULT_DELIM;
         quote_ff <= csvt_pkg::DEFAULT_QUOTE;
      end else if (csr_we) begin
         unique case (csr_addr)
            csvt_pkg::REG_DELIM: delim_ff <= csr_wdata;
            csvt_pkg::REG_QUOTE: quote_ff <= csr_wdata;
         endcase
      end
   end

   assign cfg.delim = (delim_ff == 8'd0) ? csvt_pkg::DEFAULT_DELIM : delim_ff;
   assign cfg.quote = (quote_ff == 8'd0) ? csvt_pkg::DEFAULT_QUOTE : quote_ff;

endmodule

`default_nettype wire

@@ design/csvt_parse.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer parser
// Parse state, held CR and counters, and the results that one request yields.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              mode,
   input  wire logic [7:0]        data_byte,
   input  wire csvt_pkg::cfg_type cfg,
   output csvt_pkg::push_type     push
);

   localparam logic [csvt_pkg::COLUMN_BITS-1:0] COL_MAX = '1;
   localparam logic [csvt_pkg::ROW_BITS-1:0]    ROW_MAX = '1;

   csvt_pkg::parse_state_type state_ff, state_in;
   logic                                row_started_ff, row_started_in;
   logic                                pending_ff, pending_in;
   logic [csvt_pkg::COLUMN_BITS-1:0]    field_ff, field_in;
   logic [csvt_pkg::ROW_BITS-1:0]       row_ff, row_in;
   logic [csvt_pkg::COLUMN_BITS-1:0]    widest_ff, widest_in;

   logic is_delim, is_quote, is_lf, is_cr, is_zero;
   logic fin_go, byte_go;

   logic                              do_end, end_lf, end_delim, do_content, quote_err;
   logic                              clr_pending, set_started, pend_eff, cr_emit;
   logic                              main_valid;
   csvt_pkg::kind_type                main_kind;
   logic [7:0]                        main_byte;
   logic [csvt_pkg::COLUMN_BITS-1:0]  field_inc, widest_new;
   csvt_pkg::rsp_item_type            cr_item, main_item;

   assign is_delim = (data_byte == cfg.delim);
   assign is_quote = (data_byte == cfg.quote);
   assign is_lf    = (data_byte == csvt_pkg::CH_LF);
   assign is_cr    = (data_byte == csvt_pkg::CH_CR);
   assign is_zero  = (data_byte == csvt_pkg::CH_NUL);

   // A zero byte finishes the document just as an end-of-input request does.
   assign fin_go  = (mode == csvt_pkg::MODE_EOI) ||
                    (state_ff != csvt_pkg::ST_DRAINED && is_zero);
   assign byte_go = (mode == csvt_pkg::MODE_DATA) &&
                    (state_ff != csvt_pkg::ST_DRAINED) && !is_zero;

   // Next parse state.
   always_comb begin
      state_in = state_ff;
      if (mode == csvt_pkg::MODE_EOI) begin
         state_in = csvt_pkg::ST_START;
      end else if (state_ff == csvt_pkg::ST_DRAINED || is_zero) begin
         state_in = csvt_pkg::ST_DRAINED;
      end else begin
         unique case (state_ff)
            csvt_pkg::ST_PLAIN: begin
               state_in = (is_delim || is_lf) ? csvt_pkg::ST_START : csvt_pkg::ST_PLAIN;
            end
            csvt_pkg::ST_QUOTED: begin
               state_in = is_quote ? csvt_pkg::ST_QSEEN : csvt_pkg::ST_QUOTED;
            end
            csvt_pkg::ST_QSEEN: begin
               state_in = is_quote ? csvt_pkg::ST_QUOTED : csvt_pkg::ST_START;
            end
            default: begin
               if (is_quote) begin
                  state_in = csvt_pkg::ST_QUOTED;
               end else if (is_delim || is_lf) begin
                  state_in = csvt_pkg::ST_START;
               end else begin
                  state_in = csvt_pkg::ST_PLAIN;
               end
            end
         endcase
      end
   end

   // Events of this request.
   always_comb begin
      do_end      = 1'b0;
      end_lf      = 1'b0;
      end_delim   = 1'b0;
      do_content  = 1'b0;
      quote_err   = 1'b0;
      clr_pending = 1'b0;
      set_started = 1'b0;
      if (fin_go) begin
         unique case (state_ff)
            csvt_pkg::ST_DRAINED: ;
            csvt_pkg::ST_PLAIN,
            csvt_pkg::ST_QSEEN:   do_end = 1'b1;
            csvt_pkg::ST_QUOTED: begin
               quote_err   = 1'b1;
               clr_pending = 1'b1;
            end
            default:              do_end = row_started_ff;
         endcase
      end else if (byte_go) begin
         unique case (state_ff)
            csvt_pkg::ST_PLAIN: begin
               if (is_delim || is_lf) begin
                  do_end    = 1'b1;
                  end_lf    = is_lf;
                  end_delim = is_delim;
               end else begin
                  do_content = 1'b1;
               end
            end
            csvt_pkg::ST_QUOTED: begin
               do_content = !is_quote;
            end
            csvt_pkg::ST_QSEEN: begin
               if (is_quote) begin
                  do_content = 1'b1;
               end else begin
                  do_end    = 1'b1;
                  end_lf    = is_lf;
                  end_delim = is_delim;
               end
            end
            default: begin
               set_started = 1'b1;
               clr_pending = 1'b1;
               if (!is_quote && (is_delim || is_lf)) begin
                  do_end    = 1'b1;
                  end_lf    = is_lf;
                  end_delim = is_delim;
               end else if (!is_quote) begin
                  do_content = 1'b1;
               end
            end
         endcase
      end
   end

   assign field_inc  = (field_ff != COL_MAX) ? field_ff + 1'b1 : field_ff;
   assign widest_new = (field_inc > widest_ff) ? field_inc : widest_ff;

   // A held CR is sent ahead of content or of a field or row end, but dropped before a newline.
   assign pend_eff = pending_ff && !clr_pending;
   assign cr_emit  = pend_eff && (do_content || (do_end && !end_lf));

   always_comb begin
      main_valid = 1'b0;
      main_kind  = csvt_pkg::KIND_BYTE;
      main_byte  = 8'd0;
      if (quote_err) begin
         main_valid = 1'b1;
         main_kind  = csvt_pkg::KIND_QUOTE_ERR;
      end else if (do_end) begin
         main_valid = 1'b1;
         main_kind  = end_delim ? csvt_pkg::KIND_FIELD_END : csvt_pkg::KIND_ROW_END;
      end else if (do_content && !is_cr) begin
         main_valid = 1'b1;
         main_byte  = data_byte;
      end
   end

   always_comb begin
      cr_item.kind         = csvt_pkg::KIND_BYTE;
      cr_item.out_byte     = csvt_pkg::CH_CR;
      cr_item.column_index = field_ff;
      cr_item.row_index    = row_ff;
      cr_item.widest_row   = widest_ff;
      cr_item.last         = !main_valid;

      main_item.kind         = main_kind;
      main_item.out_byte     = main_byte;
      main_item.column_index = field_ff;
      main_item.row_index    = row_ff;
      main_item.widest_row   = (main_kind == csvt_pkg::KIND_ROW_END) ? widest_new : widest_ff;
      main_item.last         = 1'b1;

      push.item1 = main_item;
      if (cr_emit) begin
         push.item0 = cr_item;
         push.count = main_valid ? 2'd2 : 2'd1;
      end else begin
         push.item0 = main_item;
         push.count = main_valid ? 2'd1 : 2'd0;
      end
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   // Next values of the held CR, the row flag and the counters.
   always_comb begin
      pending_in     = pend_eff;
      row_started_in = row_started_ff || set_started;
      field_in       = field_ff;
      row_in         = row_ff;
      widest_in      = widest_ff;
      if (do_content) begin
         pending_in = is_cr;
      end else if (do_end) begin
         pending_in = 1'b0;
      end
      if (do_end && end_delim) begin
         field_in       = field_inc;
         row_started_in = 1'b1;
      end else if (do_end) begin
         widest_in      = widest_new;
         row_in         = (row_ff != ROW_MAX) ? row_ff + 1'b1 : row_ff;
         field_in       = '0;
         row_started_in = 1'b0;
      end
      if (mode == csvt_pkg::MODE_EOI) begin
         pending_in     = 1'b0;
         row_started_in = 1'b0;
         field_in       = '0;
         row_in         = '0;
         widest_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= csvt_pkg::ST_START;
         row_started_ff <= 1'b0;
         pending_ff     <= 1'b0;
         field_ff       <= '0;
         row_ff         <= '0;
         widest_ff      <= '0;
      end else if (accept) begin
         state_ff       <= state_in;
         row_started_ff <= row_started_in;
         pending_ff     <= pending_in;
         field_ff       <= field_in;
         row_ff         <= row_in;
         widest_ff      <= widest_in;
      end
   end

endmodule

`default_nettype wire

@@ design/csvt_rsp_fifo.sv @@
// ----------------------------------------------------------------------------
// CSV tokenizer result queue
// Small register queue that takes up to two results a cycle and gives one while the reader is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire csvt_pkg::push_type push,
   output logic                   space_ok,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output csvt_pkg::rsp_item_type out_item
);

   localparam logic [csvt_pkg::RSP_CNT_W-1:0] SPACE_LIMIT =
      csvt_pkg::RSP_CNT_W'(csvt_pkg::RSP_DEPTH - 2);

   csvt_pkg::rsp_item_type              slot_ff [csvt_pkg::RSP_DEPTH];
   logic [csvt_pkg::RSP_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [csvt_pkg::RSP_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [csvt_pkg::RSP_CNT_W-1:0]      count_ff, count_in;
   logic                                pop;

   assign out_valid = (count_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_item  = slot_ff[rd_ptr_ff];
   // Room for the two results that the next request may yield.
   assign space_ok  = (count_ff <= SPACE_LIMIT);

   assign wr_ptr_in = wr_ptr_ff + csvt_pkg::RSP_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + csvt_pkg::RSP_PTR_W'(pop);
   assign count_in  = count_ff + csvt_pkg::RSP_CNT_W'(push.count)
                      - csvt_pkg::RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_ff + 1'b1] <= push.item1;
      end
   end

endmodule

`default_nettype wire

@@ design/csv_field_tokenizer.sv @@
// Results are written into the result queue at the edge that accepts their request.
// Throughput: one request per cycle while the queue has room for two more results; a
// request that yields two results (a held CR ahead of the next one) occupies the
// result port once for each, and a four-entry result queue absorbs the difference.
// Reset is synchronous: it clears the parse state, counters and queue, and sets the
// delimiter and quote registers to comma and double quote.
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Streams CSV text a byte at a time and gives decoded bytes, field and row ends, and quote errors.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  wire logic                                req_tuser,  // [0] mode
   // Result channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] out_byte, then column_index, row_index, widest_row
   output logic [csvt_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   output logic [1:0]                               rsp_tuser,  // [1:0] kind
   output logic                                     rsp_tlast,
   // Configuration port
   input  wire logic                                csr_we,
   input  wire logic [0:0]                          csr_addr,
   input  wire logic [7:0]                          csr_wdata
);

   csvt_pkg::cfg_type       cfg;
   csvt_pkg::push_type      push;
   csvt_pkg::rsp_item_type  head;
   logic                    accept;
   logic                    space_ok;

   assign req_tready = space_ok;
   assign accept     = req_tvalid && req_tready;

   csvt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   csvt_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_tuser),
      .data_byte (req_tdata),
      .cfg       (cfg),
      .push      (push)
   );

   csvt_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = csvt_pkg::RSP_TDATA_W'({head.widest_row, head.row_index,
                                              head.column_index, head.out_byte});
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   // Field ends, row ends and errors are always the final result of their request.
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != csvt_pkg::KIND_BYTE |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("marker result without tlast or with a non-zero byte");

   // The request side only stalls while results are queued.
   a_stall_backed: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with an empty result queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered straight after reset");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// Streams directed and random CSV text through the tokenizer under several
// delimiter and quote settings, with random idling on both channels, and
// checks every result against a cycle-free model of the tokenizer.
// ----------------------------------------------------------------------------

module tb_top;
   import csvt_pkg::*;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'd0;   // [7:0] data_byte
   logic                   req_tuser  = MODE_DATA; // [0] mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] out_byte, then column_index, row_index, widest_row
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [1:0]             rsp_tuser;           // [1:0] kind
   logic                   rsp_tlast;
   logic                   csr_we     = 1'b0;
   logic [0:0]             csr_addr   = REG_DELIM;
   logic [7:0]             csr_wdata  = 8'd0;

   // Follows the parse state and counters and holds the tokens still owed.
   class token_tracker;
      logic [7:0]             delim_reg;
      logic [7:0]             quote_reg;
      parse_state_type        pstate;
      bit                     row_open;
      bit                     cr_held;
      logic [COLUMN_BITS-1:0] field_cnt;
      logic [COLUMN_BITS-1:0] widest_cnt;
      logic [ROW_BITS-1:0]    row_cnt;
      rsp_item_type           pending_tokens[$];
      rsp_item_type           step_tokens[$];
      int                     errors;

      function new();
         delim_reg = DEFAULT_DELIM;
         quote_reg = DEFAULT_QUOTE;
         errors    = 0;
         restart();
      endfunction

      function void restart();
         pstate     = ST_START;
         row_open   = 1'b0;
         cr_held    = 1'b0;
         field_cnt  = '0;
         widest_cnt = '0;
         row_cnt    = '0;
      endfunction

      function void write_reg(logic [0:0] idx, logic [7:0] val);
         if (idx == REG_DELIM) begin
            delim_reg = val;
         end else begin
            quote_reg = val;
         end
      endfunction

      function logic [7:0] delim_eff();
         return (delim_reg != 8'd0) ? delim_reg : DEFAULT_DELIM;
      endfunction

      function logic [7:0] quote_eff();
         return (quote_reg != 8'd0) ? quote_reg : DEFAULT_QUOTE;
      endfunction

      function void push_token(kind_type k, logic [7:0] b);
         rsp_item_type t;
         t.kind         = k;
         t.out_byte     = b;
         t.column_index = field_cnt;
         t.row_index    = row_cnt;
         t.widest_row   = widest_cnt;
         t.last         = 1'b0;
         step_tokens.push_back(t);
      endfunction

      // A CR is kept back until the next byte shows whether a newline follows.
      function void text_byte(logic [7:0] b);
         if (cr_held) begin
            push_token(KIND_BYTE, CH_CR);
            cr_held = 1'b0;
         end
         if (b == CH_CR) begin
            cr_held = 1'b1;
         end else begin
            push_token(KIND_BYTE, b);
         end
      endfunction

      function void close_field(logic [7:0] term, bit at_end);
         logic [COLUMN_BITS-1:0] fields;
         if (!at_end && term == CH_LF) begin
            cr_held = 1'b0;
         end else if (cr_held) begin
            push_token(KIND_BYTE, CH_CR);
            cr_held = 1'b0;
         end
         // The delimiter wins over a newline when the two are the same byte.
         if (!at_end && term == delim_eff()) begin
            push_token(KIND_FIELD_END, 8'd0);
            if (field_cnt != '1) field_cnt = field_cnt + 1'b1;
            row_open = 1'b1;
         end else begin
            fields = (field_cnt != '1) ? field_cnt + 1'b1 : field_cnt;
            if (fields > widest_cnt) widest_cnt = fields;
            push_token(KIND_ROW_END, 8'd0);
            if (row_cnt != '1) row_cnt = row_cnt + 1'b1;
            field_cnt = '0;
            row_open  = 1'b0;
         end
         pstate = ST_START;
      endfunction

      function void close_doc();
         case (pstate)
            ST_DRAINED: ;
            ST_PLAIN, ST_QSEEN: close_field(8'd0, 1'b1);
            ST_QUOTED: begin
               cr_held = 1'b0;
               push_token(KIND_QUOTE_ERR, 8'd0);
            end
            default: if (row_open) close_field(8'd0, 1'b1);
         endcase
      endfunction

      function void note_request(logic mode, logic [7:0] b);
         rsp_item_type t;
         step_tokens.delete();
         if (mode == MODE_EOI) begin
            close_doc();
            restart();
         end else if (pstate != ST_DRAINED) begin
            if (b == CH_NUL) begin
               close_doc();
               pstate = ST_DRAINED;
            end else begin
               case (pstate)
                  ST_PLAIN: begin
                     if (b == delim_eff() || b == CH_LF) close_field(b, 1'b0);
                     else text_byte(b);
                  end
                  ST_QUOTED: begin
                     if (b == quote_eff()) pstate = ST_QSEEN;
                     else text_byte(b);
                  end
                  ST_QSEEN: begin
                     if (b == quote_eff()) begin
                        text_byte(b);
                        pstate = ST_QUOTED;
                     end else begin
                        close_field(b, 1'b0);
                     end
                  end
                  default: begin
                     row_open = 1'b1;
                     cr_held  = 1'b0;
                     if (b == quote_eff()) begin
                        pstate = ST_QUOTED;
                     end else if (b == delim_eff() || b == CH_LF) begin
                        close_field(b, 1'b0);
                     end else begin
                        text_byte(b);
                        pstate = ST_PLAIN;
                     end
                  end
               endcase
            end
         end
         if (step_tokens.size() > 0) begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
         end
         foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_token(logic [1:0] kind, logic [RSP_TDATA_W-1:0] data, logic last);
         rsp_item_type t;
         if (pending_tokens.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d data %0h", kind, data));
            return;
         end
         t = pending_tokens.pop_front();
         compare_field("kind", 32'(kind), 32'(t.kind));
         compare_field("out_byte", 32'(data[7:0]), 32'(t.out_byte));
         compare_field("column_index", 32'(data[8 +: COLUMN_BITS]), 32'(t.column_index));
         compare_field("row_index", 32'(data[8+COLUMN_BITS +: ROW_BITS]),
                       32'(t.row_index));
         compare_field("widest_row", 32'(data[8+COLUMN_BITS+ROW_BITS +: COLUMN_BITS]),
                       32'(t.widest_row));
         compare_field("last", 32'(last), 32'(t.last));
      endtask
   endclass

   token_tracker tracker = new();
   bit           steady_send = 1'b0;
   bit           steady_recv = 1'b0;
   int           items_sent  = 0;

   csv_field_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_token(rsp_tuser, rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) tracker.note_request(req_tuser, req_tdata);
      end
   end

   initial begin : rsp_pacer
      int hold;
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         hold = $urandom_range(1, 12);
         repeat (hold) @(posedge clock);
         stall = pick_gap(steady_recv);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // tvalid is left high on return so that back-to-back requests need no toggle.
   task automatic send_request(logic mode, logic [7:0] b);
      int gap;
      gap = pick_gap(steady_send);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_request(MODE_DATA, s[i]);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [7:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_reg(idx, val);
      @(posedge clock);
   endtask

   // Holds the sender off until every owed token has come back or a guard runs out,
   // then idles before it returns.
   task automatic settle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (tracker.pending_tokens.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_text();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return CH_CR;
      if (r < 35) return 8'($urandom_range(1, 255));
      return 8'($urandom_range(8'h61, 8'h7a));
   endfunction

   task automatic send_plain_field();
      int         len;
      logic [7:0] b;
      len = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
         do b = pick_text();
         while (b == tracker.delim_eff() || b == CH_LF ||
                (i == 0 && b == tracker.quote_eff()));
         send_request(MODE_DATA, b);
      end
   endtask

   task automatic send_quoted_field();
      int         len;
      logic [7:0] b;
      len = $urandom_range(0, 5);
      send_request(MODE_DATA, tracker.quote_eff());
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_request(MODE_DATA, tracker.quote_eff());
            send_request(MODE_DATA, tracker.quote_eff());
         end else begin
            case ($urandom_range(0, 5))
               0: b = tracker.delim_eff();
               1: b = CH_LF;
               default: b = pick_text();
            endcase
            if (b != tracker.quote_eff()) send_request(MODE_DATA, b);
         end
      end
      send_request(MODE_DATA, tracker.quote_eff());
   endtask

   task automatic send_row();
      int nf;
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
         if (f > 0) send_request(MODE_DATA, tracker.delim_eff());
         if ($urandom_range(0, 2) == 0) send_quoted_field();
         else send_plain_field();
      end
      if ($urandom_range(0, 2) == 0) send_request(MODE_DATA, CH_CR);
      send_request(MODE_DATA, CH_LF);
   endtask

   task automatic random_phase(int target);
      int r;
      int n;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            send_row();
         end else if (r < 88) begin
            n = $urandom_range(1, 4);
            repeat (n) send_request(MODE_DATA, 8'($urandom_range(1, 255)));
         end else if (r < 93) begin
            send_request(MODE_EOI, 8'($urandom_range(0, 255)));
         end else if (r < 97) begin
            // Quoted field cut short by the end of input.
            send_request(MODE_DATA, tracker.quote_eff());
            send_plain_field();
            send_request(MODE_EOI, 8'($urandom_range(0, 255)));
         end else begin
            // A zero byte ends the document; what follows is ignored until end of input.
            send_row();
            send_request(MODE_DATA, CH_NUL);
            n = $urandom_range(0, 2);
            repeat (n) send_request(MODE_DATA, 8'($urandom_range(0, 255)));
            send_request(MODE_EOI, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin : stimulus
      logic [7:0] delim_set[8];
      logic [7:0] quote_set[8];
      logic [7:0] d;
      logic [7:0] q;
      delim_set = '{8'd0, 8'd255, 8'd59, 8'd9, 8'd44, 8'd10, 8'd13, 8'd124};
      quote_set = '{8'd0, 8'd255, 8'd39, 8'd34, 8'd0, 8'd34, 8'd39, 8'd96};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Doubled quote, and a held CR inside a quoted field flushed at the delimiter after it.
      send_text("\"a\"\"\r\",");
      // Stray CR after a closing quote ends the row; the newline then is an empty line.
      send_text("\"q\"\r\n");
      send_text("b\r\n");
      send_request(MODE_DATA, 8'hff);
      send_text("\ry");
      send_request(MODE_EOI, 8'hff);
      send_text("\"\r");
      send_request(MODE_EOI, 8'h00);
      send_request(MODE_EOI, 8'h00);
      send_text("a");
      send_request(MODE_DATA, CH_NUL);
      send_text("b");
      send_request(MODE_EOI, 8'h5a);
      settle();

      // Delimiter equal to newline: the field ends, the row does not.
      write_csr(REG_DELIM, CH_LF);
      send_text("a\r\n");
      send_request(MODE_EOI, 8'h00);
      settle();

      for (int p = 0; p < 8; p++) begin
         d = delim_set[p];
         q = quote_set[p];
         if (p == 7) begin
            d = 8'($urandom_range(0, 255));
            q = 8'($urandom_range(0, 255));
         end
         write_csr(REG_DELIM, d);
         write_csr(REG_QUOTE, q);
         steady_send = (p % 3 == 1);
         steady_recv = (p % 4 == 2);
         random_phase(items_sent + 65);
         settle();
      end

      steady_send = 1'b0;
      steady_recv = 1'b0;
      settle();
      if (tracker.pending_tokens.size() != 0)
         tracker.report_mismatch($sformatf("%0d results never arrived",
                                           tracker.pending_tokens.size()));
      repeat (8) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
design/csvt_pkg.sv
design/csvt_csr.sv
design/csvt_parse.sv
design/csvt_rsp_fifo.sv
design/csv_field_tokenizer.sv
dv/tb_top.sv
